// ----- rtl/core/fir_filter_delay_compensated_assert.svh -----
// Assertion macros for the delay-compensated FIR filter.
// Needs signals named clock and reset in the module that includes it.
`ifndef FIR_FILTER_DELAY_COMPENSATED_ASSERT_SVH
`define FIR_FILTER_DELAY_COMPENSATED_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FIRDC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define FIRDC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/firdc_pkg.sv -----
// Shared constants and request codes for the delay-compensated FIR filter.
// No dependencies.
package firdc_pkg;

   localparam int MaxTaps      = 64;
   localparam int SampleWidth  = 16;
   localparam int AddrWidth    = $clog2(MaxTaps);
   localparam int TapCntWidth  = 7;
   localparam int MaxDelay     = MaxTaps / 2;
   localparam int DelayWidth   = $clog2(MaxDelay) + 1;
   localparam int ProdWidth    = 2 * SampleWidth;
   localparam int AccWidth     = ProdWidth + AddrWidth + 1;
   localparam int FracBits     = SampleWidth - 1;
   localparam int SampleMax    = 2 ** (SampleWidth - 1) - 1;
   localparam int ReqTypeWidth = 2;
   localparam int CoefIdxWidth = 6;

   localparam logic [ReqTypeWidth-1:0] ReqSample = 2'd0;
   localparam logic [ReqTypeWidth-1:0] ReqFlush  = 2'd1;
   localparam logic [ReqTypeWidth-1:0] ReqCoef   = 2'd2;
   localparam logic [ReqTypeWidth-1:0] ReqNone   = 2'd3;

   typedef logic signed [SampleWidth-1:0] sample_type;

endpackage

// ----- rtl/core/firdc_channels.sv -----
// Handshake channel interfaces of the delay-compensated FIR filter.
// Depends on firdc_pkg.
interface firdc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [firdc_pkg::ReqTypeWidth-1:0]       req_type;
   firdc_pkg::sample_type                    sample_in;
   logic [firdc_pkg::CoefIdxWidth-1:0]       coef_index;
   firdc_pkg::sample_type                    coef_value;
   modport source (output valid, req_type, sample_in, coef_index, coef_value, input ready);
   modport sink   (input valid, req_type, sample_in, coef_index, coef_value, output ready);
endinterface

interface firdc_rsp_if;
   logic                  valid;
   logic                  ready;
   firdc_pkg::sample_type sample_out;
   logic                  last;
   modport source (output valid, sample_out, last, input ready);
   modport sink   (input valid, sample_out, last, output ready);
endinterface

interface firdc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [firdc_pkg::TapCntWidth-1:0] tap_count;
   modport source (output valid, tap_count, input ready);
   modport sink   (input valid, tap_count, output ready);
endinterface

// ----- rtl/core/fir_filter_delay_compensated.sv -----
// Delay-compensated streaming FIR filter: history and tap memories, one MAC per cycle.
// Depends on firdc_pkg, the channel interfaces in firdc_channels.sv and the assert header.
//
//   channel   dir  carries                                      done when
//   req_bus   in   req_type, sample_in, coef_index, coef_value  valid & ready
//   rsp_bus   out  sample_out, last                             valid & ready
//   csr_bus   in   tap_count                                    valid & ready
//
// A sample request is paced by the single multiply-accumulate that walks the history
//   memory one tap per cycle over the T taps in use.
// A flush runs D = T/2 zero-sample steps; coefficient writes and idle codes end when accepted.
// Reset is synchronous; history reads as zero after it through per-entry valid bits.
// A stalled result holds in the output register; the next request is still taken,
//   and the block only waits when a new result is due while the old one is unread.

`include "fir_filter_delay_compensated_assert.svh"

module fir_filter_delay_compensated (
   input logic         clock,
   input logic         reset,
   firdc_req_if.sink   req_bus,
   firdc_rsp_if.source rsp_bus,
   firdc_csr_if.sink   csr_bus
);

   localparam int AW = firdc_pkg::AddrWidth;
   localparam int NT = firdc_pkg::MaxTaps;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SHIFT  = 3'd1;  // shift a zero in for a flush step
   localparam logic [2:0] ST_MAC    = 3'd2;  // issue one tap read per cycle
   localparam logic [2:0] ST_DRAIN  = 3'd3;  // let read/multiply stages empty
   localparam logic [2:0] ST_RESULT = 3'd4;  // round, drop or emit

   // tap memories
   firdc_pkg::sample_type hist_mem [NT];
   firdc_pkg::sample_type coef_mem [NT];

   // control state
   logic [2:0]                          state_ff, state_in;
   logic [AW-1:0]                       ptr_ff, ptr_in;        // newest history entry
   logic [NT-1:0]                       hvalid_ff, hvalid_in;  // entry holds a real sample
   logic [firdc_pkg::DelayWidth-1:0]    dropped_ff, dropped_in;
   logic                                flush_ff, flush_in;
   logic [firdc_pkg::DelayWidth-1:0]    left_ff, left_in;      // flush steps to go
   logic [firdc_pkg::TapCntWidth-1:0]   tap_k_ff, tap_k_in;
   logic [firdc_pkg::TapCntWidth-1:0]   tap_count_ff;
   logic                                s1_ff, s2_ff;          // pipe stage occupancy
   logic                                rsp_valid_ff, rsp_valid_in;

   // datapath
   firdc_pkg::sample_type               hist_rd_ff, coef_rd_ff;
   logic                                hv_rd_ff;
   logic signed [firdc_pkg::ProdWidth-1:0] prod_ff;
   logic signed [firdc_pkg::AccWidth-1:0]  acc_ff, acc_in;
   firdc_pkg::sample_type               rsp_data_ff, rsp_data_in;
   logic                                rsp_last_ff, rsp_last_in;

   // derived values
   logic [firdc_pkg::TapCntWidth-1:0]   eff_taps;
   logic [firdc_pkg::DelayWidth-1:0]    delay;
   logic                                accept;
   logic                                rsp_free;
   logic                                hist_we, coef_we;
   logic [AW-1:0]                       ptr_next;
   logic [AW-1:0]                       rd_addr;
   firdc_pkg::sample_type               hmask;
   logic signed [firdc_pkg::AccWidth-1:0]  rnd, quot, sat_hi, sat_lo;
   firdc_pkg::sample_type               sat_val;
   logic                                emit;

   // taps in use clamped to [1, MaxTaps]; output advance is half of it
   always_comb begin
      priority if (tap_count_ff == '0) begin
         eff_taps = firdc_pkg::TapCntWidth'(1);
      end else if (tap_count_ff > firdc_pkg::TapCntWidth'(NT)) begin
         eff_taps = firdc_pkg::TapCntWidth'(NT);
      end else begin
         eff_taps = tap_count_ff;
      end
   end
   assign delay = firdc_pkg::DelayWidth'(eff_taps >> 1);

   assign csr_bus.ready  = 1'b1;
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign accept         = req_bus.valid && req_bus.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_bus.ready;
   assign ptr_next       = ptr_ff + AW'(1);
   assign rd_addr        = ptr_ff - tap_k_ff[AW-1:0];

   // round half up, floor shift, saturate
   assign sat_hi  = firdc_pkg::AccWidth'(firdc_pkg::SampleMax);
   assign sat_lo  = -sat_hi - firdc_pkg::AccWidth'(1);
   assign rnd     = acc_ff + (firdc_pkg::AccWidth'(1) <<< (firdc_pkg::FracBits - 1));
   assign quot    = rnd >>> firdc_pkg::FracBits;
   always_comb begin
      priority if (quot > sat_hi) begin
         sat_val = firdc_pkg::SampleWidth'(sat_hi);
      end else if (quot < sat_lo) begin
         sat_val = firdc_pkg::SampleWidth'(sat_lo);
      end else begin
         sat_val = firdc_pkg::SampleWidth'(quot);
      end
   end
   assign emit = (dropped_ff >= delay);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      hvalid_in    = hvalid_ff;
      dropped_in   = dropped_ff;
      flush_in     = flush_ff;
      left_in      = left_ff;
      tap_k_in     = tap_k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      acc_in       = s2_ff ? acc_ff + firdc_pkg::AccWidth'(prod_ff) : acc_ff;
      hist_we      = 1'b0;
      coef_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_bus.req_type)
                  firdc_pkg::ReqSample: begin
                     hist_we             = 1'b1;
                     ptr_in              = ptr_next;
                     hvalid_in[ptr_next] = 1'b1;
                     flush_in            = 1'b0;
                     acc_in              = '0;
                     tap_k_in            = '0;
                     state_in            = ST_MAC;
                  end
                  firdc_pkg::ReqFlush: begin
                     if (delay == '0) begin
                        hvalid_in  = '0;
                        dropped_in = '0;
                     end else begin
                        flush_in = 1'b1;
                        left_in  = delay;
                        state_in = ST_SHIFT;
                     end
                  end
                  firdc_pkg::ReqCoef: begin
                     coef_we   = 1'b1;
                     hvalid_in = '0;
                  end
                  firdc_pkg::ReqNone: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // a zero sample: just mark the new slot empty
            ptr_in              = ptr_next;
            hvalid_in[ptr_next] = 1'b0;
            acc_in              = '0;
            tap_k_in            = '0;
            state_in            = ST_MAC;
         end
         ST_MAC: begin
            tap_k_in = tap_k_ff + firdc_pkg::TapCntWidth'(1);
            if (tap_k_ff == eff_taps - firdc_pkg::TapCntWidth'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!emit || rsp_free) begin
               if (!emit) begin
                  dropped_in = dropped_ff + firdc_pkg::DelayWidth'(1);
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = sat_val;
                  rsp_last_in  = flush_ff && (left_ff == firdc_pkg::DelayWidth'(1));
               end
               if (flush_ff) begin
                  left_in = left_ff - firdc_pkg::DelayWidth'(1);
                  if (left_ff == firdc_pkg::DelayWidth'(1)) begin
                     hvalid_in  = '0;
                     dropped_in = '0;
                     state_in   = ST_IDLE;
                  end else begin
                     state_in = ST_SHIFT;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         hvalid_ff    <= '0;
         dropped_ff   <= '0;
         flush_ff     <= 1'b0;
         left_ff      <= '0;
         tap_k_ff     <= '0;
         tap_count_ff <= firdc_pkg::TapCntWidth'(1);
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         hvalid_ff    <= hvalid_in;
         dropped_ff   <= dropped_in;
         flush_ff     <= flush_in;
         left_ff      <= left_in;
         tap_k_ff     <= tap_k_in;
         s1_ff        <= (state_ff == ST_MAC);
         s2_ff        <= s1_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            tap_count_ff <= csr_bus.tap_count;
         end
      end
   end

   // memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[ptr_next] <= req_bus.sample_in;
      end
      hist_rd_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[req_bus.coef_index] <= req_bus.coef_value;
      end
      coef_rd_ff <= coef_mem[tap_k_ff[AW-1:0]];
   end

   // multiply stage, accumulator, output register
   assign hmask = hv_rd_ff ? hist_rd_ff : '0;

   always_ff @(posedge clock) begin
      hv_rd_ff    <= hvalid_ff[rd_addr];
      prod_ff     <= hmask * coef_rd_ff;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_data_ff;
   assign rsp_bus.last       = rsp_last_ff;

   `FIRDC_ASSERT_IMP(a_drop_bound, 1'b1, dropped_ff <= firdc_pkg::DelayWidth'(firdc_pkg::MaxDelay), "drop count past half the tap limit")
   `FIRDC_ASSERT_NXT(a_emit_source, !rsp_valid_ff && state_ff != ST_RESULT, !rsp_valid_ff, "result appeared outside the result step")
   `FIRDC_ASSERT_IMP(a_shift_pending, state_ff == ST_SHIFT, flush_ff && left_ff != '0, "flush step with nothing left")
   `FIRDC_ASSERT_IMP(a_pipe_empty, state_ff == ST_IDLE || state_ff == ST_SHIFT, !s1_ff && !s2_ff, "MAC pipe busy at a new sum")
   `FIRDC_ASSERT_IMP(a_tap_range, state_ff == ST_MAC, tap_k_ff < eff_taps, "tap read beyond taps in use")

endmodule
